[rtl/core/rgbc_pkg.sv]
package rgbc_pkg;

  localparam int CH_W        = 8;
  localparam int NUM_CH      = 3;
  localparam int PIX_W       = NUM_CH * CH_W;
  localparam int LB_W        = 2 * PIX_W;
  localparam int KERNEL_SIZE = 3;

  localparam int COEF_W         = 12;
  localparam int COEF_FRAC_BITS = 8;
  // 12-bit signed coef times 8-bit pixel fits 20 bits; three of them 22, nine 24
  localparam int PROD_W = 20;
  localparam int COL_W  = 22;
  localparam int SUM_W  = 24;

  localparam int CFG_W        = KERNEL_SIZE * COEF_W;
  localparam int CFG_IDX_W    = 3;
  localparam int SIZE_W       = 11;
  localparam int SIZE_RESET   = 32;
  localparam int HEIGHT_LIMIT = 1024;
  localparam int ROW_W        = $clog2(HEIGHT_LIMIT);

  localparam int DEF_MAX_WIDTH = 1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_TOP    = 3'd0,
    REG_COEF_MIDDLE = 3'd1,
    REG_COEF_BOTTOM = 3'd2,
    REG_WIDTH       = 3'd3,
    REG_HEIGHT      = 3'd4
  } reg_idx_t;

  // channel 0 is red, in the low bits
  typedef logic [NUM_CH-1:0][CH_W-1:0] rgb_t;
  // one window column, element 0 is the top row
  typedef rgb_t [KERNEL_SIZE-1:0] col_t;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t [KERNEL_SIZE-1:0] coef_col_t;

  typedef logic signed [COL_W-1:0] csum_t;
  typedef csum_t [NUM_CH-1:0] csum_vec_t;

  typedef struct packed {
    logic step;   // whole pipeline advances
    logic shift;  // a new column enters the window
  } cell_ctl_t;

  function automatic logic [CH_W-1:0] clamp_chan(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] sh;
    logic [CH_W-1:0] r;
    sh = s >>> COEF_FRAC_BITS;
    if (s[SUM_W-1]) begin
      r = '0;
    end else if (sh[SUM_W-1:CH_W] != '0) begin
      r = '1;
    end else begin
      r = sh[CH_W-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/core/rgbc_ifs.sv]
interface rgbc_pix_if import rgbc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_in;
  logic [CH_W-1:0] green_in;
  logic [CH_W-1:0] blue_in;
  logic            frame_start;

  modport source (output valid, red_in, green_in, blue_in, frame_start, input ready);
  modport sink (input valid, red_in, green_in, blue_in, frame_start, output ready);
endinterface

interface rgbc_res_if import rgbc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_out;
  logic [CH_W-1:0] green_out;
  logic [CH_W-1:0] blue_out;
  logic            frame_last;

  modport source (output valid, red_out, green_out, blue_out, frame_last, input ready);
  modport sink (input valid, red_out, green_out, blue_out, frame_last, output ready);
endinterface

[rtl/core/rgbc_line_buf.sv]
module rgbc_line_buf import rgbc_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  logic [LB_W-1:0] wr_data,
  output logic [LB_W-1:0] rd_data
);

  // upper line in the high half, lower line in the low half
  logic [LB_W-1:0] mem [MAX_WIDTH];
  logic [LB_W-1:0] mem_q;
  logic [LB_W-1:0] fwd_data;
  logic            fwd;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q    <= mem[rd_addr];
      fwd_data <= wr_data;
    end
  end

  // a read that meets a write to the same entry on the same edge takes the new word
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (rd_en) begin
      fwd <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd ? fwd_data : mem_q;

endmodule

[rtl/core/rgbc_cell.sv]
module rgbc_cell import rgbc_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  col_t      col_in,
  input  coef_col_t coef,
  output col_t      col_out,
  output csum_vec_t col_sum
);

  col_t                    col_q;
  logic signed [PROD_W-1:0] prod_q    [KERNEL_SIZE][NUM_CH];
  logic signed [PROD_W-1:0] prod_next [KERNEL_SIZE][NUM_CH];
  csum_vec_t               sum_q;
  csum_vec_t               sum_next;

  always_comb begin
    for (int r = 0; r < KERNEL_SIZE; r++) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        prod_next[r][ch] = PROD_W'($signed(coef[r]))
                         * $signed(PROD_W'({1'b0, col_q[r][ch]}));
      end
    end
  end

  always_comb begin
    logic signed [COL_W-1:0] acc;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      acc = '0;
      for (int r = 0; r < KERNEL_SIZE; r++) begin
        acc = acc + COL_W'(prod_q[r][ch]);
      end
      sum_next[ch] = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      col_q <= col_in;
    end
    if (ctl.step) begin
      prod_q <= prod_next;
      sum_q  <= sum_next;
    end
  end

  assign col_out = col_q;
  assign col_sum = sum_q;

endmodule

[rtl/core/rgb_conv3x3_clamp.sv]
// Channel    Dir  Carries
// pixel      in   red_in, green_in, blue_in, frame_start (raster order)
// filtered   out  red_out, green_out, blue_out, frame_last (valid region only)
// cfg_*      in   write-only registers: coefficient rows, width, height
//
// One item per clock while ready is high. An accepted item crosses the line
// store read stage, a chain of three column cells and their product and
// column-sum registers to the output register. Ready is low only while the
// skid slot behind a stalled output is full; the whole pipeline then holds.
// Synchronous reset clears counters, valid bits and config; not line stores.
module rgb_conv3x3_clamp import rgbc_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  rgbc_pix_if.sink             pixel,
  rgbc_res_if.source           filtered,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int VW      = (CW + 1 > SIZE_W) ? CW + 1 : SIZE_W;
  localparam int W_RESET = (SIZE_RESET > MAX_WIDTH) ? MAX_WIDTH : SIZE_RESET;

  // configuration
  logic [CFG_W-1:0]  coef_top, coef_mid, coef_bot;
  logic [CW-1:0]     w_last, w_last_next;
  logic [ROW_W-1:0]  h_last, h_last_next;
  logic [VW-1:0]     wv;
  logic [SIZE_W-1:0] hv;

  always_comb begin
    wv = VW'(cfg_data[SIZE_W-1:0]);
    hv = cfg_data[SIZE_W-1:0];
    if (wv < VW'(KERNEL_SIZE)) begin
      w_last_next = CW'(KERNEL_SIZE - 1);
    end else if (wv > VW'(MAX_WIDTH)) begin
      w_last_next = CW'(MAX_WIDTH - 1);
    end else begin
      w_last_next = CW'(wv - VW'(1));
    end
    if (hv < SIZE_W'(KERNEL_SIZE)) begin
      h_last_next = ROW_W'(KERNEL_SIZE - 1);
    end else if (hv > SIZE_W'(HEIGHT_LIMIT)) begin
      h_last_next = ROW_W'(HEIGHT_LIMIT - 1);
    end else begin
      h_last_next = ROW_W'(hv - SIZE_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_top <= '0;
      coef_mid <= '0;
      coef_bot <= '0;
      w_last   <= CW'(W_RESET - 1);
      h_last   <= ROW_W'(SIZE_RESET - 1);
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_COEF_TOP:    coef_top <= cfg_data;
        REG_COEF_MIDDLE: coef_mid <= cfg_data;
        REG_COEF_BOTTOM: coef_bot <= cfg_data;
        REG_WIDTH:       w_last   <= w_last_next;
        REG_HEIGHT:      h_last   <= h_last_next;
        default: ;
      endcase
    end
  end

  // input side and position
  logic             en, acc;
  logic             skid_valid;
  logic [CW-1:0]    col_cnt, col_cur;
  logic [ROW_W-1:0] row_cnt, row_cur;
  logic             line_end, frame_end, emit;
  rgb_t             in_pix;

  assign en          = !skid_valid;
  assign pixel.ready = en;
  assign acc         = pixel.valid && en;
  assign in_pix      = {pixel.blue_in, pixel.green_in, pixel.red_in};

  assign col_cur   = pixel.frame_start ? '0 : col_cnt;
  assign row_cur   = pixel.frame_start ? '0 : row_cnt;
  assign line_end  = col_cur >= w_last;
  assign frame_end = line_end && (row_cur >= h_last);
  assign emit      = (row_cur >= ROW_W'(KERNEL_SIZE - 1)) && (col_cur >= CW'(KERNEL_SIZE - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (acc) begin
      if (line_end) begin
        col_cnt <= '0;
        row_cnt <= frame_end ? '0 : row_cur + ROW_W'(1);
      end else begin
        col_cnt <= col_cur + CW'(1);
        row_cnt <= row_cur;
      end
    end
  end

  // stage 1: line store read returns
  logic          v1, emit1, last1;
  rgb_t          pix1, top1, mid1;
  logic [CW-1:0] col1;
  logic [LB_W-1:0] lb_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      pix1  <= in_pix;
      col1  <= col_cur;
      emit1 <= emit;
      last1 <= frame_end;
    end
  end

  rgbc_line_buf #(.MAX_WIDTH(MAX_WIDTH)) u_line_buf (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (acc),
    .rd_addr(col_cur),
    .wr_en  (en && v1),
    .wr_addr(col1),
    .wr_data({mid1, pix1}),
    .rd_data(lb_rd)
  );

  assign top1 = lb_rd[LB_W-1:PIX_W];
  assign mid1 = lb_rd[PIX_W-1:0];

  // window: chain of column cells, oldest column in cell 0
  cell_ctl_t ctl;
  col_t      new_col;
  col_t      chain_in  [KERNEL_SIZE];
  col_t      cell_col  [KERNEL_SIZE];
  coef_col_t cell_coef [KERNEL_SIZE];
  csum_vec_t cell_sum  [KERNEL_SIZE];

  assign ctl.step  = en;
  assign ctl.shift = en && v1;
  assign new_col   = {pix1, mid1, top1};

  for (genvar k = 0; k < KERNEL_SIZE; k++) begin : g_cell
    if (k == KERNEL_SIZE - 1) begin : g_head
      assign chain_in[k] = new_col;
    end else begin : g_link
      assign chain_in[k] = cell_col[k+1];
    end
    assign cell_coef[k] = {coef_bot[k*COEF_W +: COEF_W],
                           coef_mid[k*COEF_W +: COEF_W],
                           coef_top[k*COEF_W +: COEF_W]};

    rgbc_cell u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .col_in (chain_in[k]),
      .coef   (cell_coef[k]),
      .col_out(cell_col[k]),
      .col_sum(cell_sum[k])
    );
  end

  // valid and frame-end travel alongside window, product and column-sum stages
  logic v2, v3, v4;
  logic last2, last3, last4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v2 <= v1 && emit1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      last2 <= last1;
      last3 <= last2;
      last4 <= last3;
    end
  end

  logic signed [SUM_W-1:0] total [NUM_CH];
  rgb_t res;

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      total[ch] = '0;
      for (int k = 0; k < KERNEL_SIZE; k++) begin
        total[ch] = total[ch] + SUM_W'($signed(cell_sum[k][ch]));
      end
      res[ch] = clamp_chan(total[ch]);
    end
  end

  // output register plus one skid slot
  logic out_valid, out_last, skid_last;
  rgb_t out_data, skid_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (filtered.ready) begin
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || filtered.ready) begin
      out_valid <= v4;
    end else if (v4) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (filtered.ready) begin
        out_data <= skid_data;
        out_last <= skid_last;
      end
    end else if (!out_valid || filtered.ready) begin
      out_data <= res;
      out_last <= last4;
    end else begin
      skid_data <= res;
      skid_last <= last4;
    end
  end

  assign filtered.valid      = out_valid;
  assign filtered.red_out    = out_data[0];
  assign filtered.green_out  = out_data[1];
  assign filtered.blue_out   = out_data[2];
  assign filtered.frame_last = out_last;

endmodule

[rtl/core/rgbc_checker.sv]
module rgbc_sva (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // input back-pressure only behind a waiting result
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("ready low with no result waiting");

  a_ready_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("ready dropped without an output stall");

  // no result straight after reset: an item must cross every pipeline register first
  a_reset_latency: assert property (@(posedge clk)
    $past(rst, 4) |-> !out_valid)
    else $error("result too soon after reset");

endmodule

bind rgb_conv3x3_clamp rgbc_sva u_rgbc_sva (
  .clk      (clk),
  .rst      (rst),
  .in_ready (pixel.ready),
  .out_valid(filtered.valid),
  .out_ready(filtered.ready)
);

[tb/sv/rgbc_checker.sv]
`timescale 1ns / 100ps

// Watches the pixel, filtered and register ports, keeps its own copy of the
// line stores, window and position counters, and checks every accepted result.
module rgbc_checker import rgbc_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  rgbc_pix_if                  pixel,
  rgbc_res_if                  filtered,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   err_count,
  output int                   pending
);

  typedef struct packed {
    rgb_t px;
    logic last;
  } filt_item_t;

  filt_item_t       expected_px [$];
  logic [CFG_W-1:0] coef_rows [KERNEL_SIZE];
  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;
  rgb_t             upper_st [MAX_WIDTH];
  rgb_t             lower_st [MAX_WIDTH];
  rgb_t             win [9];
  int unsigned      col_pos;
  int unsigned      row_pos;

  initial begin
    err_count = 0;
    pending   = 0;
  end

  function automatic logic [CH_W-1:0] conv_channel(int ch);
    longint acc;
    coef_t  k;
    acc = 0;
    for (int r = 0; r < KERNEL_SIZE; r++) begin
      for (int c = 0; c < KERNEL_SIZE; c++) begin
        k = coef_rows[r][c*COEF_W +: COEF_W];
        acc += longint'(k) * longint'(win[r*3+c][ch]);
      end
    end
    if (acc < 0) return '0;
    acc = acc >>> COEF_FRAC_BITS;
    if (acc > 255) return '1;
    return acc[CH_W-1:0];
  endfunction

  function automatic void clear_state();
    coef_rows[0] = '0;
    coef_rows[1] = '0;
    coef_rows[2] = '0;
    width_reg  = SIZE_W'(SIZE_RESET);
    height_reg = SIZE_W'(SIZE_RESET);
    for (int i = 0; i < MAX_WIDTH; i++) begin
      upper_st[i] = '0;
      lower_st[i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i] = '0;
    col_pos = 0;
    row_pos = 0;
    expected_px.delete();
  endfunction

  // one accepted pixel: move the window along and queue the result it causes
  function automatic void advance_window(rgb_t px, logic fs);
    int unsigned eff_w, eff_h, c, r;
    rgb_t        top_px, mid_px;
    logic        line_end, frame_end;
    filt_item_t  item;
    eff_w = (width_reg < KERNEL_SIZE) ? KERNEL_SIZE :
            (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    eff_h = (height_reg < KERNEL_SIZE) ? KERNEL_SIZE :
            (height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg;
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = col_pos;
    r = row_pos;
    if (c >= MAX_WIDTH) c = MAX_WIDTH - 1;
    top_px = upper_st[c];
    mid_px = lower_st[c];
    upper_st[c] = mid_px;
    lower_st[c] = px;
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      win[i*3]   = win[i*3+1];
      win[i*3+1] = win[i*3+2];
    end
    win[2] = top_px;
    win[5] = mid_px;
    win[8] = px;
    line_end  = (c >= eff_w - 1);
    frame_end = line_end && (r >= eff_h - 1);
    if (r >= KERNEL_SIZE - 1 && c >= KERNEL_SIZE - 1) begin
      item.px[0] = conv_channel(0);
      item.px[1] = conv_channel(1);
      item.px[2] = conv_channel(2);
      item.last  = frame_end;
      expected_px = {expected_px, item};
    end
    if (line_end) begin
      col_pos = 0;
      row_pos = frame_end ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endfunction

  always @(posedge clk) begin
    filt_item_t want;
    if (rst) begin
      clear_state();
    end else begin
      if (cfg_write) begin
        case (reg_idx_t'(cfg_index))
          REG_COEF_TOP:    coef_rows[0] = cfg_data;
          REG_COEF_MIDDLE: coef_rows[1] = cfg_data;
          REG_COEF_BOTTOM: coef_rows[2] = cfg_data;
          REG_WIDTH:       width_reg    = cfg_data[SIZE_W-1:0];
          REG_HEIGHT:      height_reg   = cfg_data[SIZE_W-1:0];
          default: ;
        endcase
      end
      if (pixel.valid && pixel.ready) begin
        advance_window({pixel.blue_in, pixel.green_in, pixel.red_in}, pixel.frame_start);
      end
      if (filtered.valid && filtered.ready) begin
        if (expected_px.size() == 0) begin
          $display("%0t: unexpected item, expected none, got r %0d g %0d b %0d last %0b",
                   $time, filtered.red_out, filtered.green_out, filtered.blue_out,
                   filtered.frame_last);
          err_count++;
        end else begin
          want = expected_px.pop_front();
          if (filtered.red_out !== want.px[0]) begin
            $display("%0t: red_out expected %0d actual %0d", $time, want.px[0],
                     filtered.red_out);
            err_count++;
          end
          if (filtered.green_out !== want.px[1]) begin
            $display("%0t: green_out expected %0d actual %0d", $time, want.px[1],
                     filtered.green_out);
            err_count++;
          end
          if (filtered.blue_out !== want.px[2]) begin
            $display("%0t: blue_out expected %0d actual %0d", $time, want.px[2],
                     filtered.blue_out);
            err_count++;
          end
          if (filtered.frame_last !== want.last) begin
            $display("%0t: frame_last expected %0b actual %0b", $time, want.last,
                     filtered.frame_last);
            err_count++;
          end
        end
      end
    end
    pending <= expected_px.size();
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import rgbc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          PHASE_ITEMS = 40;

  logic clk = 1'b0;
  logic rst;

  rgbc_pix_if pix_ch ();
  rgbc_res_if filt_ch ();

  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int          err_count;
  int          pending;
  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;
  int unsigned cycle_cnt = 0;

  rgb_conv3x3_clamp dut (
    .clk       (clk),
    .rst       (rst),
    .pixel     (pix_ch),
    .filtered  (filt_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rgbc_checker chk (
    .clk       (clk),
    .rst       (rst),
    .pixel     (pix_ch),
    .filtered  (filt_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .err_count (err_count),
    .pending   (pending)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    filt_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic void set_idling(int m);
    case (m)
      0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      1: begin src_idle_pct = 54; sink_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  sink_stall_pct = 54; end
      default: begin src_idle_pct = 26; sink_stall_pct = 26; end
    endcase
  endfunction

  function automatic int eff_size(int v, int hi);
    if (v < KERNEL_SIZE) return KERNEL_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [CFG_W-1:0] krow(coef_t l, coef_t m, coef_t r);
    return {r, m, l};
  endfunction

  task automatic pick_kernel(input int kind, output logic [CFG_W-1:0] kt,
                             output logic [CFG_W-1:0] km, output logic [CFG_W-1:0] kb);
    logic [CFG_W-1:0] rows [KERNEL_SIZE];
    coef_t            k;
    for (int i = 0; i < 9; i++) begin
      case (kind)
        0: k = coef_t'($urandom);
        1: k = coef_t'($urandom_range(100) - 30);
        2: k = coef_t'($urandom_range(60));
        // sharpening: strong centre, negative surround
        default: k = (i == 4) ? coef_t'(256 + $urandom_range(400))
                              : coef_t'(0 - $urandom_range(40));
      endcase
      rows[i/3][(i%3)*COEF_W +: COEF_W] = k;
    end
    kt = rows[0];
    km = rows[1];
    kb = rows[2];
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
  endtask

  task automatic load_settings(logic [CFG_W-1:0] kt, logic [CFG_W-1:0] km,
                               logic [CFG_W-1:0] kb, int w, int h);
    write_reg(REG_COEF_TOP, kt);
    write_reg(REG_COEF_MIDDLE, km);
    write_reg(REG_COEF_BOTTOM, kb);
    write_reg(REG_WIDTH, CFG_W'(w));
    write_reg(REG_HEIGHT, CFG_W'(h));
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic send_pixel(rgb_t px, logic fs);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.red_in      <= px[0];
    pix_ch.green_in    <= px[1];
    pix_ch.blue_in     <= px[2];
    pix_ch.frame_start <= fs;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
  endtask

  // fill < 0 gives random pixels, else every channel takes fill
  task automatic send_run(int n, logic first_fs, int fill, logic noise);
    rgb_t px;
    logic fs;
    for (int i = 0; i < n; i++) begin
      if (fill >= 0) begin
        px = {3{fill[7:0]}};
      end else begin
        case ($urandom_range(9))
          0: px = '0;
          1: px = '1;
          default: px = 24'($urandom);
        endcase
      end
      fs = (i == 0) ? first_fs : 1'b0;
      if (noise && $urandom_range(99) < 2) fs = 1'b1;
      send_pixel(px, fs);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    pix_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    // items with no result may still be in the pipe
    repeat (12) @(posedge clk);
  endtask

  initial begin
    logic [CFG_W-1:0] kt, km, kb;
    int               w_reg, h_reg, ew, eh, sent, n, kind;
    logic             fs;

    rst                = 1'b1;
    pix_ch.valid       = 1'b0;
    pix_ch.red_in      = '0;
    pix_ch.green_in    = '0;
    pix_ch.blue_in     = '0;
    pix_ch.frame_start = 1'b0;
    filt_ch.ready      = 1'b0;
    cfg_write          = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // largest coefficients on white: clamps high
    set_idling(0);
    load_settings(krow(12'h7FF, 12'h7FF, 12'h7FF), krow(12'h7FF, 12'h7FF, 12'h7FF),
                  krow(12'h7FF, 12'h7FF, 12'h7FF), 3, 3);
    send_run(9, 1'b1, 255, 1'b0);
    // most negative coefficients: sum below zero
    wait_idle();
    load_settings(krow(12'h800, 12'h800, 12'h800), krow(12'h800, 12'h800, 12'h800),
                  krow(12'h800, 12'h800, 12'h800), 3, 3);
    send_run(9, 1'b1, 255, 1'b0);
    // half-weight centre truncates odd pixels; no frame_start, counters wrapped
    wait_idle();
    set_idling(3);
    load_settings('0, krow(12'h000, 12'h080, 12'h000), '0, 3, 3);
    send_run(9, 1'b0, -1, 1'b0);
    // size shrunk in the middle of a frame
    wait_idle();
    pick_kernel(1, kt, km, kb);
    load_settings(kt, km, kb, 4, 4);
    send_run(6, 1'b1, -1, 1'b0);
    wait_idle();
    load_settings(kt, km, kb, 3, 3);
    send_run(4, 1'b0, -1, 1'b0);

    // size extremes: one widest line and a bit with height below range,
    // then the opening rows of the tallest frame
    wait_idle();
    set_idling(0);
    pick_kernel(2, kt, km, kb);
    load_settings(kt, km, kb, 2047, 0);
    send_run(DEF_MAX_WIDTH + 32, 1'b1, -1, 1'b0);
    wait_idle();
    set_idling(2);
    pick_kernel(1, kt, km, kb);
    load_settings(kt, km, kb, 1, 2047);
    send_run(KERNEL_SIZE * 80, 1'b1, -1, 1'b0);

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      set_idling(ph % 4);
      pick_kernel($urandom_range(3), kt, km, kb);
      case ($urandom_range(7))
        0: begin w_reg = $urandom_range(2); h_reg = $urandom_range(6); end
        1: begin w_reg = $urandom_range(64, 20); h_reg = $urandom_range(4, 3); end
        2: begin w_reg = $urandom_range(9, 3); h_reg = $urandom_range(2); end
        default: begin w_reg = $urandom_range(14, 3); h_reg = $urandom_range(8, 3); end
      endcase
      load_settings(kt, km, kb, w_reg, h_reg);
      ew = eff_size(w_reg, DEF_MAX_WIDTH);
      eh = eff_size(h_reg, HEIGHT_LIMIT);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        kind = $urandom_range(9);
        n    = ew * eh;
        fs   = 1'b1;
        // first frame of a phase always opens with frame_start
        if (kind == 0 && sent != 0) fs = 1'b0;
        else if (kind == 1) n = $urandom_range(n - 1, 1);
        send_run(n, fs, -1, kind > 7);
        sent += n;
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/rgbc_pkg.sv
rtl/core/rgbc_ifs.sv
rtl/core/rgbc_line_buf.sv
rtl/core/rgbc_cell.sv
rtl/core/rgb_conv3x3_clamp.sv
rtl/core/rgbc_checker.sv
tb/sv/rgbc_checker.sv
tb/sv/tb_top.sv
